// ===== hw/rtl/pidq_pkg.sv =====
// Package for the process ID queue: default sizes, command codes, FSM states
// and the per-cell control struct. No dependencies.
package pidq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int ID_WIDTH_DEF = 8;

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_DUMP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } t_state;

    // load wins over shift inside a cell
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/pidq_if.sv =====
// Request and response channel interfaces for the process ID queue.
// Depends on pidq_pkg.
interface pidq_in_if #(
    parameter int ID_WIDTH = pidq_pkg::ID_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    pidq_pkg::t_cmd      command;
    logic [ID_WIDTH-1:0] process_id;

    modport source (output valid, command, process_id, input ready);
    modport sink   (input valid, command, process_id, output ready);
endinterface

interface pidq_out_if #(
    parameter int ID_WIDTH = pidq_pkg::ID_WIDTH_DEF,
    parameter int CNT_W    = $clog2(pidq_pkg::DEPTH_DEF + 1)
);
    logic                valid;
    logic                ready;
    logic                found;
    logic [CNT_W-1:0]    count;
    logic [ID_WIDTH-1:0] entry_id;
    logic                entry_valid;
    logic                last;
    logic                status;

    modport source (output valid, found, count, entry_id, entry_valid, last, status,
                    input ready);
    modport sink   (input valid, found, count, entry_id, entry_valid, last, status,
                    output ready);
endinterface

// ===== hw/rtl/process_id_queue_with_removal_core.sv =====
// Process ID queue with remove-by-value: top level (cell chain + sweep control).
// Enqueue: result registered the cycle after accept.
// Remove / query / dump: the chain rotates once, one entry per cycle through
// the head cell while the response slot is free; an empty queue skips the
// sweep. Every sweep step waits for the response side. Sync active-low reset empties the queue;
// stored IDs are not cleared. Depends on pidq_pkg, pidq_if, pidq_cell.
module process_id_queue_with_removal_core #(
    parameter int DEPTH    = pidq_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = pidq_pkg::ID_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pidq_in_if.sink   i_req,
    pidq_out_if.source o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // ---------------- cell chain ----------------
    logic [ID_WIDTH-1:0]  w_id    [DEPTH];
    logic                 w_valid [DEPTH];
    pidq_pkg::t_cell_ctl  w_ctl   [DEPTH];
    logic [ID_WIDTH-1:0]  w_load_id;

    // ---------------- control state ----------------
    pidq_pkg::t_state     r_state;
    logic [CNT_W-1:0]     r_count;   // entries held
    logic [CNT_W-1:0]     r_rem;     // entries still to pass the head in this sweep
    logic [CNT_W-1:0]     r_sz;      // occupied span of the chain during a sweep
    pidq_pkg::t_cmd       r_cmd;
    logic [ID_WIDTH-1:0]  r_key;
    logic                 r_hit;

    // response register
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [CNT_W-1:0]     r_out_count;
    logic [ID_WIDTH-1:0]  r_out_id;
    logic                 r_out_ev;
    logic                 r_out_last;
    logic                 r_out_status;

    logic                 out_free;
    logic                 in_fire;
    logic                 enq_fire;
    logic                 full;
    logic                 step;
    logic                 head_match;
    logic                 keep;
    logic                 last_step;
    logic [CNT_W-1:0]     sz_next;
    logic [CNT_W-1:0]     tail_idx;

    // Response slot frees when empty or being taken this cycle.
    assign out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == pidq_pkg::ST_IDLE) && out_free;
    assign in_fire  = i_req.valid && i_req.ready;
    assign enq_fire = in_fire && (i_req.command == pidq_pkg::CMD_ENQ);
    assign full     = (r_count == CNT_W'(DEPTH));

    // Sweep: each step pops the head and re-appends it at the tail unless a
    // remove drops it. After r_count steps the order is restored, gaps closed.
    assign step       = (r_state == pidq_pkg::ST_SWEEP) && out_free;
    assign head_match = (w_id[0] == r_key);
    assign keep       = !((r_cmd == pidq_pkg::CMD_REMOVE) && head_match);
    assign last_step  = (r_rem == CNT_W'(1));
    assign sz_next    = keep ? r_sz : r_sz - CNT_W'(1);
    assign tail_idx   = r_sz - CNT_W'(1);
    assign w_load_id  = step ? w_id[0] : i_req.process_id;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ID_WIDTH-1:0] nbr_id;
        logic                nbr_valid;

        if (i == DEPTH - 1) begin : g_end
            assign nbr_id    = '0;
            assign nbr_valid = 1'b0;
        end else begin : g_mid
            assign nbr_id    = w_id[i+1];
            assign nbr_valid = w_valid[i+1];
        end

        // enqueue writes slot r_count; a sweep writes the kept head to the
        // last slot of the shifted span
        assign w_ctl[i].shift = step;
        assign w_ctl[i].load  = (enq_fire && !full && (r_count == CNT_W'(i)))
                             || (step && keep && (tail_idx == CNT_W'(i)));

        pidq_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl[i]),
            .i_load_id   (w_load_id),
            .i_nbr_id    (nbr_id),
            .i_nbr_valid (nbr_valid),
            .o_id        (w_id[i]),
            .o_valid     (w_valid[i])
        );
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pidq_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                pidq_pkg::ST_IDLE: begin
                    if (enq_fire && !full) begin
                        r_count <= r_count + CNT_W'(1);
                    end else if (in_fire && !enq_fire && (r_count != '0)) begin
                        r_state <= pidq_pkg::ST_SWEEP;
                    end
                end
                pidq_pkg::ST_SWEEP: begin
                    if (step && last_step) begin
                        r_state <= pidq_pkg::ST_IDLE;
                        r_count <= sz_next;
                    end
                end
                default: begin
                    r_state <= pidq_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // sweep bookkeeping, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_req.command;
            r_key <= i_req.process_id;
            r_rem <= r_count;
            r_sz  <= r_count;
            r_hit <= 1'b0;
        end else if (step) begin
            r_rem <= r_rem - CNT_W'(1);
            r_sz  <= sz_next;
            r_hit <= r_hit || head_match;
        end
    end

    // ---------------- response register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((in_fire && (enq_fire || (r_count == '0)))
                     || (step && ((r_cmd == pidq_pkg::CMD_DUMP) || last_step))) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            // enqueue, or any other request on an empty queue: one result now
            r_out_found  <= 1'b0;
            r_out_count  <= (enq_fire && !full) ? r_count + CNT_W'(1) : r_count;
            r_out_id     <= '0;
            r_out_ev     <= 1'b0;
            r_out_last   <= 1'b1;
            r_out_status <= enq_fire && full;
        end else if (step) begin
            r_out_found  <= (r_cmd == pidq_pkg::CMD_QUERY) && (r_hit || head_match);
            r_out_count  <= (r_cmd == pidq_pkg::CMD_REMOVE) ? sz_next : r_count;
            r_out_id     <= (r_cmd == pidq_pkg::CMD_DUMP) ? w_id[0] : '0;
            r_out_ev     <= (r_cmd == pidq_pkg::CMD_DUMP);
            r_out_last   <= last_step;
            r_out_status <= 1'b0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.count       = r_out_count;
    assign o_rsp.entry_id    = r_out_id;
    assign o_rsp.entry_valid = r_out_ev;
    assign o_rsp.last        = r_out_last;
    assign o_rsp.status      = r_out_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_sweep_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pidq_pkg::ST_SWEEP) |-> (r_rem != '0) && (r_rem <= r_sz))
        else $error("sweep span lost track of pending entries");

    a_sweep_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !enq_fire && (r_count != '0)) |=> (r_state == pidq_pkg::ST_SWEEP))
        else $error("non-enqueue request did not start a sweep");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && last_step) |=> (r_count <= $past(r_count)))
        else $error("sweep grew the queue");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pidq_pkg::ST_IDLE) |-> (w_valid[0] == (r_count != '0)))
        else $error("head cell valid disagrees with count");
`endif

endmodule

// ===== hw/rtl/pidq_cell.sv =====
// One queue slot: an ID and its valid flag. Loads a new ID or takes its
// right neighbor's contents. Depends on pidq_pkg.
module pidq_cell #(
    parameter int ID_WIDTH = pidq_pkg::ID_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pidq_pkg::t_cell_ctl i_ctl,
    input  logic [ID_WIDTH-1:0] i_load_id,
    input  logic [ID_WIDTH-1:0] i_nbr_id,
    input  logic                i_nbr_valid,
    output logic [ID_WIDTH-1:0] o_id,
    output logic                o_valid
);

    logic [ID_WIDTH-1:0] r_id, n_id;
    logic                r_valid, n_valid;

    always_comb begin
        n_id    = r_id;
        n_valid = r_valid;
        if (i_ctl.load) begin
            n_id    = i_load_id;
            n_valid = 1'b1;
        end else if (i_ctl.shift) begin
            n_id    = i_nbr_id;
            n_valid = i_nbr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_id    = r_id;
    assign o_valid = r_valid;

endmodule
